// ----- rtl/hbrp_pkg.sv -----
// Shared types, character codes and status codes of the byte range parser.
package hbrp_pkg;

	localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] PREFIX_LAST = 3'd5;

	localparam logic [1:0] ST_INVALID = 2'd0;
	localparam logic [1:0] ST_UNSAT   = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	typedef enum logic [1:0] {
		SPEC_SUFFIX,
		SPEC_OPEN,
		SPEC_EXPLICIT
	} spec_kind_t;

	// One command from the parser to the range unit.
	typedef struct packed {
		logic        spec_vld;
		spec_kind_t  kind;
		logic [62:0] a;        // explicit/open: range start
		logic [62:0] b;        // suffix: length, explicit: inclusive end
		logic        end_vld;  // header closed, emit status after any range
		logic        fail;     // header invalid
	} cmd_t;

	// Characters of "bytes=" by position.
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h62;
			3'd1: c = 8'h79;
			3'd2: c = 8'h74;
			3'd3: c = 8'h65;
			3'd4: c = 8'h73;
			3'd5: c = 8'h3D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/hbrp_front.sv -----
// Character parser: prefix match, number accumulation and spec classification.
module hbrp_front import hbrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] ch,
	input  logic       eoh,
	output logic       push,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_N1_START,
		PH_N1,
		PH_DASH,
		PH_N2_START,
		PH_N2,
		PH_COMMA
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  pos_q, pos_d;
	logic        neg_q, neg_d;
	logic        hd_q, hd_d;
	logic [62:0] val_q, val_d;
	logic [62:0] start_q, start_d;
	logic        seen_q, seen_d;
	logic        fail_q, fail_d;

	logic        is_dig;
	logic [3:0]  dig;
	logic        st_ok;
	logic        st_neg;
	logic [62:0] st_val;
	logic [66:0] acc_sum;
	logic [66:0] limit;
	logic        ovf;
	logic [62:0] acc_val;
	logic        num_neg_nz;

	assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dig     = 4'(ch - CH_ZERO);
	assign st_neg  = (ch == CH_DASH);
	assign st_ok   = st_neg || (ch == CH_PLUS) || is_dig;
	assign st_val  = is_dig ? {59'd0, dig} : 63'd0;

	// 10*v + d against the limit of the sign; 2^63 is allowed for a negative number.
	assign acc_sum = ({4'd0, val_q} << 3) + ({4'd0, val_q} << 1) + {63'd0, dig};
	assign limit   = neg_q ? {4'd0, MAX63} + 67'd1 : {4'd0, MAX63};
	assign ovf     = acc_sum > limit;
	assign acc_val = (acc_sum > {4'd0, MAX63}) ? MAX63 : acc_sum[62:0];

	assign num_neg_nz = neg_q && (val_q != 63'd0);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		neg_d   = neg_q;
		hd_d    = hd_q;
		val_d   = val_q;
		start_d = start_q;
		seen_d  = seen_q;
		fail_d  = fail_q;
		cmd     = '0;
		cmd.kind = SPEC_SUFFIX;
		push    = 1'b0;
		if (acc) begin
			if (eoh) begin
				if (!fail_q) begin
					case (phase_q)
						PH_N1_START: begin
							if (!seen_q) fail_d = 1'b1;
						end
						PH_N1: begin
							if (hd_q && num_neg_nz) begin
								cmd.spec_vld = 1'b1;
								cmd.kind     = SPEC_SUFFIX;
								cmd.b        = val_q;
							end else begin
								fail_d = 1'b1;
							end
						end
						PH_DASH: begin
							cmd.spec_vld = 1'b1;
							cmd.kind     = SPEC_OPEN;
							cmd.a        = start_q;
						end
						PH_N2: begin
							if (!hd_q || num_neg_nz || (val_q < start_q)) begin
								fail_d = 1'b1;
							end else begin
								cmd.spec_vld = 1'b1;
								cmd.kind     = SPEC_EXPLICIT;
								cmd.a        = start_q;
								cmd.b        = val_q;
							end
						end
						default: fail_d = 1'b1;
					endcase
				end
				cmd.end_vld = 1'b1;
				cmd.fail    = fail_d;
				push        = 1'b1;
				// start the next header afresh
				phase_d = PH_PREFIX;
				pos_d   = 3'd0;
				neg_d   = 1'b0;
				hd_d    = 1'b0;
				val_d   = 63'd0;
				start_d = 63'd0;
				seen_d  = 1'b0;
				fail_d  = 1'b0;
			end else if (!fail_q) begin
				case (phase_q)
					PH_PREFIX: begin
						if (ch == prefix_char(pos_q)) begin
							pos_d = pos_q + 3'd1;
							if (pos_q == PREFIX_LAST) phase_d = PH_N1_START;
						end else begin
							fail_d = 1'b1;
						end
					end
					PH_N1_START, PH_COMMA: begin
						neg_d  = st_neg;
						hd_d   = is_dig;
						val_d  = st_val;
						seen_d = 1'b1;
						if (st_ok) phase_d = PH_N1;
						else fail_d = 1'b1;
					end
					PH_N1: begin
						if (is_dig) begin
							if (ovf) fail_d = 1'b1;
							else begin
								val_d = acc_val;
								hd_d  = 1'b1;
							end
						end else if (!hd_q) begin
							fail_d = 1'b1;
						end else if (num_neg_nz) begin
							cmd.spec_vld = 1'b1;
							cmd.kind     = SPEC_SUFFIX;
							cmd.b        = val_q;
							push         = 1'b1;
							if (ch == CH_COMMA) begin
								phase_d = PH_COMMA;
							end else begin
								neg_d  = st_neg;
								hd_d   = is_dig;
								val_d  = st_val;
								seen_d = 1'b1;
								if (st_ok) phase_d = PH_N1;
								else fail_d = 1'b1;
							end
						end else if (ch != CH_DASH) begin
							fail_d = 1'b1;
						end else begin
							start_d = val_q;
							phase_d = PH_DASH;
						end
					end
					PH_DASH: begin
						if (ch == CH_COMMA) begin
							cmd.spec_vld = 1'b1;
							cmd.kind     = SPEC_OPEN;
							cmd.a        = start_q;
							push         = 1'b1;
							phase_d      = PH_COMMA;
						end else begin
							neg_d = st_neg;
							hd_d  = is_dig;
							val_d = st_val;
							if (st_ok) phase_d = PH_N2;
							else fail_d = 1'b1;
						end
					end
					PH_N2_START: begin
						neg_d = st_neg;
						hd_d  = is_dig;
						val_d = st_val;
						if (st_ok) phase_d = PH_N2;
						else fail_d = 1'b1;
					end
					PH_N2: begin
						if (is_dig) begin
							if (ovf) fail_d = 1'b1;
							else begin
								val_d = acc_val;
								hd_d  = 1'b1;
							end
						end else if (!hd_q || num_neg_nz || (val_q < start_q)) begin
							fail_d = 1'b1;
						end else begin
							cmd.spec_vld = 1'b1;
							cmd.kind     = SPEC_EXPLICIT;
							cmd.a        = start_q;
							cmd.b        = val_q;
							push         = 1'b1;
							if (ch == CH_COMMA) begin
								phase_d = PH_COMMA;
							end else begin
								neg_d  = st_neg;
								hd_d   = is_dig;
								val_d  = st_val;
								seen_d = 1'b1;
								if (st_ok) phase_d = PH_N1;
								else fail_d = 1'b1;
							end
						end
					end
					default: fail_d = 1'b1;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pos_q   <= 3'd0;
			neg_q   <= 1'b0;
			hd_q    <= 1'b0;
			val_q   <= 63'd0;
			start_q <= 63'd0;
			seen_q  <= 1'b0;
			fail_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			neg_q   <= neg_d;
			hd_q    <= hd_d;
			val_q   <= val_d;
			start_q <= start_d;
			seen_q  <= seen_d;
			fail_q  <= fail_d;
		end
	end

endmodule

// ----- rtl/hbrp_queue.sv -----
// Command queue between the parser and the range unit.
module hbrp_queue import hbrp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- rtl/hbrp_back.sv -----
// Range unit: clamps each spec to the file size and sequences range and status words.
module hbrp_back import hbrp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [62:0]   file_size,
	input  logic          empty,
	input  cmd_t          head,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata,
	output logic          m_axis_tuser,
	output logic          m_axis_tlast
);

	logic        rng;
	logic [62:0] beg;
	logic [62:0] endv;
	logic [63:0] e1;

	logic        s1_vld_q;
	logic        s1_rng_s1;
	logic [62:0] s1_beg_s1;
	logic [62:0] s1_end_s1;
	logic        s1_eoh_s1;
	logic        s1_fail_s1;

	logic        out_vld_q;
	logic        out_st_q;
	logic [62:0] out_beg_q;
	logic [62:0] out_end_q;
	logic [1:0]  out_status_q;
	logic        any_sat_q;

	logic        out_free;
	logic        out_load;
	logic        s1_take;

	// Decode the head command against the file size.
	always_comb begin
		e1   = {1'b0, head.b} + 64'd1;
		beg  = head.a;
		endv = file_size;
		rng  = 1'b0;
		case (head.kind)
			SPEC_SUFFIX: begin
				beg = (file_size > head.b) ? file_size - head.b : 63'd0;
				rng = (file_size != 63'd0);
			end
			SPEC_OPEN: begin
				rng = (head.a < file_size);
			end
			SPEC_EXPLICIT: begin
				endv = (e1 > {1'b0, file_size}) ? file_size : e1[62:0];
				rng  = (head.a < file_size);
			end
			default: rng = 1'b0;
		endcase
		rng = rng && head.spec_vld;
	end

	assign out_free = !out_vld_q || m_axis_tready;
	assign out_load = out_free && s1_vld_q;
	assign s1_take  = !s1_vld_q || (out_load && !(s1_rng_s1 && s1_eoh_s1));
	assign pop      = !empty && s1_take;

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_beg_s1  <= beg;
			s1_end_s1  <= endv;
			s1_fail_s1 <= head.fail;
		end
		if (out_load) begin
			if (s1_rng_s1) begin
				out_beg_q    <= s1_beg_s1;
				out_end_q    <= s1_end_s1;
				out_status_q <= ST_INVALID;
			end else begin
				out_beg_q    <= 63'd0;
				out_end_q    <= 63'd0;
				out_status_q <= s1_fail_s1 ? ST_INVALID : (any_sat_q ? ST_SAT : ST_UNSAT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			s1_rng_s1 <= 1'b0;
			s1_eoh_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			out_st_q  <= 1'b0;
			any_sat_q <= 1'b0;
		end else begin
			if (s1_take) begin
				s1_vld_q  <= pop && (rng || head.end_vld);
				s1_rng_s1 <= pop && rng;
				s1_eoh_s1 <= pop && head.end_vld;
			end else if (out_load) begin
				// range sent, status still to follow
				s1_rng_s1 <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_st_q  <= !s1_rng_s1;
				any_sat_q <= s1_rng_s1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_status_q, out_end_q, out_beg_q};
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tlast  = out_st_q;

	a_range_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_st_q) |-> (out_beg_q < out_end_q))
		else $error("empty or reversed range emitted");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_st_q) |-> (out_status_q != 2'd3))
		else $error("undefined status code emitted");

endmodule

// ----- rtl/http_byte_range_parser_unit.sv -----
// Top level of the HTTP byte range parser: parser, command queue and range unit.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata[7:0] ch, tlast end_of_header
//  m_axis    out  m_axis_tvalid/tready    tdata range_begin/range_end/status,
//                                         tuser is_status, tlast last
//  cfg       in   cfg_valid/cfg_ready     cfg_data file_size
//
// One header character is taken every cycle while the command queue is not full; the parser does one accumulate
// (10*v+d against the limit) or one 63-bit compare per character.
// A result word passes the queue slot, the range decode register and the output
// register after the edge that takes its character. An end word that closes a
// spec yields a range word and then a status word.
// Reset clears the parse state, the queue, the output register and file_size.
// A stalled output fills the QUEUE_DEPTH-word command queue before s_axis_tready
// drops; characters that give no command never take a queue slot.
module http_byte_range_parser_unit import hbrp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] ch
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // [62:0] range_begin, [125:63] range_end,
	                                     // [127:126] status
	output logic         m_axis_tuser,   // [0] is_status
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [62:0]  cfg_data
);

	logic [62:0] file_size_q;
	logic        in_acc;
	logic        push;
	cmd_t        push_cmd;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	cmd_t        q_head;

	// Configuration must land only while idle (the block does not enforce this), so take it at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= 63'd0;
		end else if (cfg_valid) begin
			file_size_q <= cfg_data;
		end
	end

	// Hold the input while the queue has no room for a command.
	assign s_axis_tready = !q_full;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	hbrp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (in_acc),
		.ch     (s_axis_tdata),
		.eoh    (s_axis_tlast),
		.push   (push),
		.cmd    (push_cmd)
	);

	hbrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	hbrp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.file_size     (file_size_q),
		.empty         (q_empty),
		.head          (q_head),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
